/* rtl/leltree_pkg.sv */
package leltree_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // coordinate table read address select
    localparam logic [2:0] CA_XL  = 3'd0;
    localparam logic [2:0] CA_XM  = 3'd1;
    localparam logic [2:0] CA_XR  = 3'd2;
    localparam logic [2:0] CA_MID = 3'd3;
    localparam logic [2:0] CA_LO  = 3'd4;

    // line evaluations: stored line (0) or new line at left, middle, right; query point
    localparam logic [2:0] EV_L0 = 3'd0;
    localparam logic [2:0] EV_M0 = 3'd1;
    localparam logic [2:0] EV_R0 = 3'd2;
    localparam logic [2:0] EV_L  = 3'd3;
    localparam logic [2:0] EV_M  = 3'd4;
    localparam logic [2:0] EV_R  = 3'd5;
    localparam logic [2:0] EV_Q  = 3'd6;

    typedef struct packed {
        logic       take;
        logic       coord_we;
        logic [2:0] ca_sel;
        logic       node_path;
        logic       cap_node;
        logic       cap_xl;
        logic       cap_xm;
        logic       cap_xr;
        logic       mul_go;
        logic       add_go;
        logic [2:0] ev;
        logic       node_we;
        logic       node_clr;
        logic       clr_init;
        logic       clr_step;
        logic       init_add;
        logic       step_level;
        logic       init_search;
        logic       search_step;
        logic       init_path;
        logic       path_step;
        logic       out_load;
        logic       out_miss;
    } dp_cmd_t;

    typedef struct packed {
        logic node_valid;
        logic lvl_zero;
        logic keep;
        logic replace;
        logic swap;
        logic leaf_better;
        logic search_done;
        logic found;
        logic path_root;
        logic clr_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/leltree_ram.sv */
module leltree_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/leltree_dp.sv */
module leltree_dp #(
    parameter int LEAVES = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  leltree_pkg::dp_cmd_t   cmd,
    output leltree_pkg::dp_stat_t  stat,
    input  logic [9:0]             slot,
    input  logic signed [31:0]     coord,
    input  logic signed [31:0]     slope,
    input  logic signed [31:0]     intercept,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [63:0]            min_value,
    output logic                   empty_res,
    output logic                   not_found
);
    import leltree_pkg::*;

    localparam int LOG_P  = $clog2(LEAVES);
    localparam int P      = 1 << LOG_P;
    localparam int NODE_W = LOG_P + 1;
    localparam int CA_W   = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int SR_W   = $clog2(LEAVES + 1);
    localparam int LV_W   = (LOG_P > 0) ? $clog2(LOG_P + 1) : 1;

    logic signed [31:0] a_reg, b_reg, a0_reg, b0_reg;
    logic               v0_reg;
    logic signed [31:0] xq_reg, xl_reg, xm_reg, xr_reg;
    logic [NODE_W-1:0]  l_reg, j_reg, i_reg, clr_reg;
    logic [LV_W-1:0]    lvl_reg;
    logic [SR_W-1:0]    lo_reg, hi_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] yl0_reg, ym0_reg, yr0_reg, yl_reg, ym_reg, yr_reg;
    logic signed [63:0] best_reg;
    logic               have_reg;
    logic               out_valid_reg;
    logic [63:0]        out_min_reg;
    logic               out_empty_reg, out_nf_reg;

    logic [NODE_W-1:0]  half, full, xm_idx, xr_idx;
    logic [SR_W:0]      sum;
    logic [SR_W-1:0]    mid;
    logic [CA_W-1:0]    ca_raddr;
    logic signed [31:0] ca_rdata;
    logic               ca_we;
    logic [NODE_W-1:0]  n_raddr, n_waddr;
    logic [64:0]        n_wdata, n_rdata;
    logic signed [31:0] mul_a, mul_x, add_b;
    logic signed [63:0] prod_next, y_sum;
    logic               step_bit;

    function automatic logic [CA_W-1:0] clamp_idx(input logic [NODE_W-1:0] idx);
        if (32'(idx) >= LEAVES)
        begin
            clamp_idx = CA_W'(LEAVES - 1);
        end
        else
        begin
            clamp_idx = CA_W'(idx);
        end
    endfunction

    assign full   = NODE_W'(1) << lvl_reg;
    assign half   = NODE_W'(1) << (lvl_reg - LV_W'(1));
    assign xm_idx = l_reg + half;
    assign xr_idx = l_reg + full - NODE_W'(1);
    assign sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid    = sum[SR_W:1];

    always_comb
    begin
        unique case (cmd.ca_sel)
            CA_XL:   ca_raddr = clamp_idx(l_reg);
            CA_XM:   ca_raddr = clamp_idx(xm_idx);
            CA_XR:   ca_raddr = clamp_idx(xr_idx);
            CA_MID:  ca_raddr = CA_W'(mid);
            CA_LO:   ca_raddr = CA_W'(lo_reg);
            default: ca_raddr = CA_W'(lo_reg);
        endcase
    end

    // drop loads beyond the table
    assign ca_we = cmd.coord_we && (32'(slot) < LEAVES);

    leltree_ram #(.WIDTH(32), .DEPTH(LEAVES)) u_coord_ram (
        .clk   (clk),
        .we    (ca_we),
        .waddr (CA_W'(slot)),
        .wdata (coord),
        .raddr (ca_raddr),
        .rdata (ca_rdata)
    );

    assign n_raddr = cmd.node_path ? i_reg : j_reg;
    assign n_waddr = cmd.node_clr ? clr_reg : j_reg;
    assign n_wdata = cmd.node_clr ? 65'd0 : {1'b1, a_reg, b_reg};

    // node word: valid, slope, intercept
    leltree_ram #(.WIDTH(65), .DEPTH(2 * P)) u_node_ram (
        .clk   (clk),
        .we    (cmd.node_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    always_comb
    begin
        unique case (cmd.ev)
            EV_L0:   begin mul_a = a0_reg; add_b = b0_reg; mul_x = xl_reg; end
            EV_M0:   begin mul_a = a0_reg; add_b = b0_reg; mul_x = xm_reg; end
            EV_R0:   begin mul_a = a0_reg; add_b = b0_reg; mul_x = xr_reg; end
            EV_L:    begin mul_a = a_reg;  add_b = b_reg;  mul_x = xl_reg; end
            EV_M:    begin mul_a = a_reg;  add_b = b_reg;  mul_x = xm_reg; end
            EV_R:    begin mul_a = a_reg;  add_b = b_reg;  mul_x = xr_reg; end
            default: begin mul_a = a0_reg; add_b = b0_reg; mul_x = xq_reg; end
        endcase
    end

    assign prod_next = mul_a * mul_x;
    assign y_sum     = prod_reg + 64'(add_b);

    assign step_bit = (ym0_reg >= ym_reg) ? (yr0_reg < yr_reg) : (yr0_reg >= yr_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            a_reg  <= slope;
            b_reg  <= intercept;
            xq_reg <= coord;
        end
        if (cmd.cap_node)
        begin
            v0_reg <= n_rdata[64];
            a0_reg <= n_rdata[63:32];
            b0_reg <= n_rdata[31:0];
        end
        if (cmd.cap_xl)
        begin
            xl_reg <= ca_rdata;
        end
        if (cmd.cap_xm)
        begin
            xm_reg <= ca_rdata;
        end
        if (cmd.cap_xr)
        begin
            xr_reg <= ca_rdata;
        end
        if (cmd.mul_go)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.add_go)
        begin
            unique case (cmd.ev)
                EV_L0:   yl0_reg <= y_sum;
                EV_M0:   ym0_reg <= y_sum;
                EV_R0:   yr0_reg <= y_sum;
                EV_L:    yl_reg  <= y_sum;
                EV_M:    ym_reg  <= y_sum;
                EV_R:    yr_reg  <= y_sum;
                default:
                begin
                    if (!have_reg || (y_sum < best_reg))
                    begin
                        best_reg <= y_sum;
                    end
                end
            endcase
        end
        if (cmd.init_path)
        begin
            best_reg <= 64'sd0;
        end
        if (cmd.step_level && (ym0_reg >= ym_reg))
        begin
            // loser of the middle goes down
            a_reg <= a0_reg;
            b_reg <= b0_reg;
        end
        if (cmd.out_load)
        begin
            out_min_reg   <= (cmd.out_miss || !have_reg) ? 64'd0 : best_reg;
            out_empty_reg <= cmd.out_miss || !have_reg;
            out_nf_reg    <= cmd.out_miss;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_reg         <= '0;
            j_reg         <= NODE_W'(1);
            lvl_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            clr_reg       <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_init)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + NODE_W'(1);
            end
            if (cmd.init_add)
            begin
                l_reg   <= '0;
                j_reg   <= NODE_W'(1);
                lvl_reg <= LV_W'(LOG_P);
            end
            else if (cmd.step_level)
            begin
                j_reg   <= (j_reg << 1) | NODE_W'(step_bit);
                l_reg   <= step_bit ? (l_reg + half) : l_reg;
                lvl_reg <= lvl_reg - LV_W'(1);
            end
            if (cmd.init_search)
            begin
                lo_reg <= '0;
                hi_reg <= SR_W'(LEAVES);
            end
            else if (cmd.search_step)
            begin
                if (ca_rdata < xq_reg)
                begin
                    lo_reg <= mid + SR_W'(1);
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            if (cmd.init_path)
            begin
                i_reg    <= NODE_W'(lo_reg) + NODE_W'(P);
                have_reg <= 1'b0;
            end
            else
            begin
                if (cmd.path_step)
                begin
                    i_reg <= i_reg >> 1;
                end
                if (cmd.add_go && (cmd.ev == EV_Q))
                begin
                    have_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.node_valid  = v0_reg;
    assign stat.lvl_zero    = (lvl_reg == '0);
    assign stat.keep        = (yl0_reg <= yl_reg) && (yr0_reg <= yr_reg);
    assign stat.replace     = (yl0_reg >= yl_reg) && (yr0_reg >= yr_reg);
    assign stat.swap        = (ym0_reg >= ym_reg);
    assign stat.leaf_better = (yl_reg < yl0_reg);
    assign stat.search_done = !(lo_reg < hi_reg);
    assign stat.found       = (32'(lo_reg) < LEAVES) && (xl_reg == xq_reg);
    assign stat.path_root   = (i_reg == NODE_W'(1));
    assign stat.clr_last    = (clr_reg == {NODE_W{1'b1}});
    assign stat.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign min_value = out_min_reg;
    assign empty_res = out_empty_reg;
    assign not_found = out_nf_reg;
endmodule

/* rtl/leltree_ctrl.sv */
module leltree_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             cmd_code,
    input  leltree_pkg::dp_stat_t  stat,
    output leltree_pkg::dp_cmd_t   cmd
);
    import leltree_pkg::*;

    localparam logic [4:0] ST_CLR    = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_A_RD   = 5'd2;
    localparam logic [4:0] ST_A_C1   = 5'd3;
    localparam logic [4:0] ST_A_C2   = 5'd4;
    localparam logic [4:0] ST_A_C3   = 5'd5;
    localparam logic [4:0] ST_E_MUL  = 5'd6;
    localparam logic [4:0] ST_E_ADD  = 5'd7;
    localparam logic [4:0] ST_A_DEC  = 5'd8;
    localparam logic [4:0] ST_L_DEC  = 5'd9;
    localparam logic [4:0] ST_Q_SR   = 5'd10;
    localparam logic [4:0] ST_Q_SC   = 5'd11;
    localparam logic [4:0] ST_Q_FC   = 5'd12;
    localparam logic [4:0] ST_Q_FK   = 5'd13;
    localparam logic [4:0] ST_P_RD   = 5'd14;
    localparam logic [4:0] ST_P_CAP  = 5'd15;
    localparam logic [4:0] ST_P_CHK  = 5'd16;
    localparam logic [4:0] ST_P_MUL  = 5'd17;
    localparam logic [4:0] ST_P_ADD  = 5'd18;
    localparam logic [4:0] ST_Q_OUT  = 5'd19;
    localparam logic [4:0] ST_Q_MISS = 5'd20;

    logic [4:0] state_reg, state_next;
    logic [2:0] ev_reg, ev_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            ev_reg    <= EV_L0;
        end
        else
        begin
            state_reg <= state_next;
            ev_reg    <= ev_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ev_next    = ev_reg;
        cmd        = '0;
        cmd.ev     = ev_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                cmd.node_we  = 1'b1;
                cmd.node_clr = 1'b1;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take = 1'b1;
                    unique case (cmd_code)
                        CMD_LOAD:  cmd.coord_we = 1'b1;
                        CMD_ADD:
                        begin
                            cmd.init_add = 1'b1;
                            state_next   = ST_A_RD;
                        end
                        CMD_QUERY:
                        begin
                            cmd.init_search = 1'b1;
                            state_next      = ST_Q_SR;
                        end
                        default:
                        begin
                            cmd.clr_init = 1'b1;
                            state_next   = ST_CLR;
                        end
                    endcase
                end
            end
            ST_A_RD:
            begin
                cmd.ca_sel = CA_XL;
                state_next = ST_A_C1;
            end
            ST_A_C1:
            begin
                cmd.cap_node = 1'b1;
                cmd.cap_xl   = 1'b1;
                cmd.ca_sel   = CA_XM;
                state_next   = ST_A_C2;
            end
            ST_A_C2:
            begin
                cmd.cap_xm = 1'b1;
                cmd.ca_sel = CA_XR;
                ev_next    = EV_L0;
                priority if (!stat.node_valid)
                begin
                    cmd.node_we = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (stat.lvl_zero)
                begin
                    state_next = ST_E_MUL;
                end
                else
                begin
                    state_next = ST_A_C3;
                end
            end
            ST_A_C3:
            begin
                cmd.cap_xr = 1'b1;
                state_next = ST_E_MUL;
            end
            ST_E_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = ST_E_ADD;
            end
            ST_E_ADD:
            begin
                cmd.add_go = 1'b1;
                priority if (stat.lvl_zero)
                begin
                    if (ev_reg == EV_L0)
                    begin
                        ev_next    = EV_L;
                        state_next = ST_E_MUL;
                    end
                    else
                    begin
                        state_next = ST_L_DEC;
                    end
                end
                else if (ev_reg == EV_R)
                begin
                    state_next = ST_A_DEC;
                end
                else
                begin
                    ev_next    = ev_reg + 3'd1;
                    state_next = ST_E_MUL;
                end
            end
            ST_A_DEC:
            begin
                priority if (stat.keep)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.replace)
                begin
                    cmd.node_we = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.node_we    = stat.swap;
                    cmd.step_level = 1'b1;
                    state_next     = ST_A_RD;
                end
            end
            ST_L_DEC:
            begin
                cmd.node_we = stat.leaf_better;
                state_next  = ST_IDLE;
            end
            ST_Q_SR:
            begin
                if (stat.search_done)
                begin
                    cmd.ca_sel = CA_LO;
                    state_next = ST_Q_FC;
                end
                else
                begin
                    cmd.ca_sel = CA_MID;
                    state_next = ST_Q_SC;
                end
            end
            ST_Q_SC:
            begin
                cmd.ca_sel      = CA_MID;
                cmd.search_step = 1'b1;
                state_next      = ST_Q_SR;
            end
            ST_Q_FC:
            begin
                cmd.cap_xl = 1'b1;
                state_next = ST_Q_FK;
            end
            ST_Q_FK:
            begin
                if (stat.found)
                begin
                    cmd.init_path = 1'b1;
                    state_next    = ST_P_RD;
                end
                else
                begin
                    state_next = ST_Q_MISS;
                end
            end
            ST_P_RD:
            begin
                cmd.node_path = 1'b1;
                state_next    = ST_P_CAP;
            end
            ST_P_CAP:
            begin
                cmd.cap_node = 1'b1;
                ev_next      = EV_Q;
                state_next   = ST_P_CHK;
            end
            ST_P_CHK:
            begin
                priority if (stat.node_valid)
                begin
                    state_next = ST_P_MUL;
                end
                else if (stat.path_root)
                begin
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    cmd.path_step = 1'b1;
                    state_next    = ST_P_RD;
                end
            end
            ST_P_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = ST_P_ADD;
            end
            ST_P_ADD:
            begin
                cmd.add_go = 1'b1;
                if (stat.path_root)
                begin
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    cmd.path_step = 1'b1;
                    state_next    = ST_P_RD;
                end
            end
            ST_Q_OUT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_Q_MISS:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_miss = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

/* rtl/lower_envelope_line_tree.sv */
// Li Chao tree keeping the lower envelope of lines y = slope*x + intercept over a
// sorted table of LEAVES coordinates (P = LEAVES rounded up to a power of two).
// s_tuser selects load coordinate, add line, query minimum or clear; only a query
// returns a transaction on the master side. One item is worked at a time, and each
// step waits on the single read port of the coordinate or node memory: an add line
// walks the tree level by level, with three coordinate reads and six line evaluations
// through one 32x32 multiplier on each level above the leaves, and a query runs a
// binary search over the coordinate table and then walks the leaf-to-root path.
// After reset and after every clear command the block sweeps all 2*P words of the
// node memory, one node a cycle (2048 words at the default), and takes no input
// during that sweep. A result waiting in the output register does not hold up the
// next input, but a following query waits to finish until that register is free.
module lower_envelope_line_tree #(
    parameter int LEAVES = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,   // slot[9:0], coord[41:10], slope[73:42],
                                     // intercept[105:74], zero pad
    input  logic [1:0]    s_tuser,   // cmd[1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // min_value[63:0]
    output logic [1:0]    m_tuser    // empty_res[0], not_found[1]
);
    import leltree_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     empty_res, not_found;

    leltree_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd_code (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    leltree_dp #(.LEAVES(LEAVES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .slot      (s_tdata[9:0]),
        .coord     (s_tdata[41:10]),
        .slope     (s_tdata[73:42]),
        .intercept (s_tdata[105:74]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .min_value (m_tdata),
        .empty_res (empty_res),
        .not_found (not_found)
    );

    assign m_tuser = {not_found, empty_res};
endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import leltree_pkg::*;

    localparam int LEAVES = 1024;
    localparam int SPAN   = 1024;

    typedef struct {
        longint value;
        bit     empty;
        bit     miss;
    } envelope_min_t;

    class envelope_scoreboard;
        int            coords[LEAVES];
        int            node_a[2*SPAN];
        int            node_b[2*SPAN];
        bit            node_on[2*SPAN];
        envelope_min_t expected_minima[$];
        int            errors;

        function new();
            errors = 0;
            foreach (node_on[i]) node_on[i] = 1'b0;
        endfunction

        function longint line_at(int a, int b, longint x);
            return longint'(a) * x + longint'(b);
        endfunction

        function longint coord_at(int unsigned i);
            if (i >= LEAVES) i = LEAVES - 1;
            return longint'(coords[i]);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t ns: mismatch: %s", $time, what);
        endtask

        function void insert_line(int a, int b);
            int unsigned l, j, w;
            int          a0, b0;
            longint      xl, xm, xr, yl0, ym0, yr0, yl, ym, yr, x;
            l = 0;
            j = 1;
            w = SPAN;
            while (w > 1)
            begin
                xl = coord_at(l);
                xm = coord_at(l + w / 2);
                xr = coord_at(l + w - 1);
                if (!node_on[j])
                begin
                    node_on[j] = 1'b1;
                    node_a[j] = a;
                    node_b[j] = b;
                    return;
                end
                a0 = node_a[j];
                b0 = node_b[j];
                yl0 = line_at(a0, b0, xl);
                ym0 = line_at(a0, b0, xm);
                yr0 = line_at(a0, b0, xr);
                yl = line_at(a, b, xl);
                ym = line_at(a, b, xm);
                yr = line_at(a, b, xr);
                if (yl0 <= yl && yr0 <= yr) return;
                if (yl0 >= yl && yr0 >= yr)
                begin
                    node_a[j] = a;
                    node_b[j] = b;
                    return;
                end
                w = w >> 1;
                if (ym0 >= ym)
                begin
                    node_a[j] = a;
                    node_b[j] = b;
                    a = a0;
                    b = b0;
                    j = j << 1;
                    if (yr0 < yr)
                    begin
                        j = j | 1;
                        l = l + w;
                    end
                end
                else
                begin
                    j = j << 1;
                    if (yr0 >= yr)
                    begin
                        j = j | 1;
                        l = l + w;
                    end
                end
            end
            x = coord_at(l);
            if (!node_on[j] || line_at(a, b, x) < line_at(node_a[j], node_b[j], x))
            begin
                node_on[j] = 1'b1;
                node_a[j] = a;
                node_b[j] = b;
            end
        endfunction

        function void note_item(logic [1:0] cmd, logic [9:0] slot, int coord, int a, int b);
            int unsigned   lo, hi, mid, i;
            envelope_min_t r;
            longint        y;
            case (cmd)
                CMD_LOAD:  if (slot < LEAVES) coords[slot] = coord;
                CMD_ADD:   insert_line(a, b);
                CMD_CLEAR: foreach (node_on[k]) node_on[k] = 1'b0;
                default:
                begin
                    lo = 0;
                    hi = LEAVES;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (longint'(coords[mid]) < longint'(coord)) lo = mid + 1;
                        else hi = mid;
                    end
                    r.value = 0;
                    r.empty = 1'b1;
                    r.miss  = 1'b1;
                    if (lo < LEAVES && coords[lo] == coord)
                    begin
                        r.miss = 1'b0;
                        for (i = lo + SPAN; i > 0; i = i >> 1)
                        begin
                            if (node_on[i])
                            begin
                                y = line_at(node_a[i], node_b[i], longint'(coord));
                                if (r.empty || y < r.value) r.value = y;
                                r.empty = 1'b0;
                            end
                        end
                    end
                    expected_minima = {expected_minima, r};
                end
            endcase
        endfunction

        task check_result(logic [63:0] data, logic [1:0] flags);
            envelope_min_t r;
            if (expected_minima.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h/%b", data, flags));
                return;
            end
            r = expected_minima.pop_front();
            if (longint'(data) != r.value)
                report_mismatch($sformatf("min_value %0d, want %0d", longint'(data), r.value));
            if (flags[0] !== r.empty)
                report_mismatch($sformatf("empty_res %b, want %b", flags[0], r.empty));
            if (flags[1] !== r.miss)
                report_mismatch($sformatf("not_found %b, want %b", flags[1], r.miss));
        endtask

        function int pending();
            return expected_minima.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    envelope_scoreboard sb;
    bit                 calm;

    lower_envelope_line_tree #(.LEAVES(LEAVES)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("lower_envelope_line_tree verification failed");
        $finish;
    end

    // receiver stalls in bursts
    initial
    begin
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && !calm && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 18);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    task send_item(logic [1:0] cmd, logic [9:0] slot, int coord, int a, int b);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, b, a, coord, slot};
        do @(posedge clk); while (!s_tready);
        sb.note_item(cmd, slot, coord, a, b);
    endtask

    // fill the first count slots in non-descending order
    task load_table(int mode, int count);
        longint v;
        v = -64'sd2147483648 + longint'($urandom_range(0, 1000));
        for (int i = 0; i < count; i++)
        begin
            case (mode)
                0: v = v + $urandom_range(1, 40);
                1: v = v + $urandom_range(0, 3);
                default: v = -64'sd2147483648 + (longint'(i) * 64'sd4294967295) / (LEAVES - 1);
            endcase
            send_item(CMD_LOAD, i[9:0], int'(v), int'($urandom), int'($urandom));
        end
    endtask

    function int pick_x();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) return sb.coords[$urandom_range(0, LEAVES - 1)];
        if (k == 7) return sb.coords[$urandom_range(0, LEAVES - 1)] + 1;
        if (k == 8) return int'($urandom);
        return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    function int pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return $urandom_range(0, 200) - 100;
        if (k < 9) return int'($urandom);
        return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    task random_items(int count);
        int k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 42) send_item(CMD_ADD, 10'($urandom), pick_x(), pick_value(), pick_value());
            else if (k < 92) send_item(CMD_QUERY, 10'($urandom), pick_x(), int'($urandom),
                                       int'($urandom));
            else if (k < 95) send_item(CMD_CLEAR, 10'($urandom), int'($urandom),
                                       int'($urandom), int'($urandom));
            else send_item(CMD_LOAD, 10'($urandom), int'($urandom), int'($urandom),
                           int'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_LOAD;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extreme lines, empty path, miss, clear
        load_table(2, LEAVES);
        send_item(CMD_QUERY, 10'd0, sb.coords[0], 0, 0);
        send_item(CMD_QUERY, 10'd0, 5, 0, 0);
        send_item(CMD_ADD, 10'h3ff, 0, 32'sh80000000, 32'sh7fffffff);
        send_item(CMD_ADD, 10'h3ff, 0, 32'sh7fffffff, 32'sh80000000);
        send_item(CMD_ADD, 10'h3ff, 0, 32'sh80000000, 32'sh80000000);
        send_item(CMD_ADD, 10'h3ff, 0, 32'sh7fffffff, 32'sh7fffffff);
        send_item(CMD_ADD, 10'h3ff, 0, 0, 0);
        send_item(CMD_ADD, 10'h3ff, 0, 1, -1);
        send_item(CMD_ADD, 10'h3ff, 0, -1, 1);
        send_item(CMD_QUERY, 10'h3ff, 32'sh80000000, 0, 0);
        send_item(CMD_QUERY, 10'h3ff, 32'sh7fffffff, 0, 0);
        send_item(CMD_QUERY, 10'h3ff, sb.coords[511], 0, 0);
        send_item(CMD_QUERY, 10'h3ff, sb.coords[512] + 1, 0, 0);
        send_item(CMD_CLEAR, 10'h3ff, 0, 0, 0);
        send_item(CMD_QUERY, 10'h3ff, sb.coords[700], 0, 0);

        // hold off until the block has drained
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);

        random_items(100);
        // reload the front slots with dense, repeated coordinates
        load_table(1, 64);
        random_items(80);
        load_table(0, 48);
        calm = 1'b1;
        random_items(80);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0) $display("lower_envelope_line_tree verification clean");
        else $display("lower_envelope_line_tree verification failed");
        $finish;
    end
endmodule
